### src/xrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xrr_pkg;

  // Request codes as they arrive on req_type.
  typedef enum logic [1:0] {
    REQ_FRAC  = 2'd0,
    REQ_MAX   = 2'd1,
    REQ_RANGE = 2'd2,
    REQ_SEED  = 2'd3
  } req_e;

  // Operations handed from the front to the back.
  typedef enum logic [1:0] {
    OP_FRAC,
    OP_ZERO,
    OP_MOD,
    OP_SEED
  } op_e;

  // One classified command. For OP_SEED, lo carries the seed.
  typedef struct packed {
    op_e         op;
    logic [63:0] lo;
    logic [63:0] diff;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL5,
    ST_MUL9,
    ST_DIV,
    ST_SUM,
    ST_HOLD,
    ST_SD_ADD,
    ST_SD_X30,
    ST_SD_MUL,
    ST_SD_X27,
    ST_SD_X31
  } state_e;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int DIV_STEPS  = 64;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [63:0] W_INIT0   = 64'h12345678deadbeef;
  localparam logic [63:0] W_INIT1   = 64'habcdef0123456789;
  localparam logic [63:0] W_INIT2   = 64'h9876543210fedcba;
  localparam logic [63:0] W_INIT3   = 64'hfedcba9876543210;
  localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

  localparam int SHIFT_B = 17;
  localparam int ROT_D   = 45;

endpackage
`default_nettype wire

### src/xrr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module xrr_front (
  input  wire logic [1:0]  req_type_i,
  input  wire logic [63:0] arg_a_i,
  input  wire logic [63:0] arg_b_i,
  output xrr_pkg::cmd_t    cmd_o
);

  logic swap;

  // Reversed bounds are detected with a signed compare.
  assign swap = $signed(arg_b_i) < $signed(arg_a_i);

  // Classify the request and prepare lower bound and span minus one.
  always_comb begin
    cmd_o.op   = xrr_pkg::OP_FRAC;
    cmd_o.lo   = '0;
    cmd_o.diff = '0;
    unique case (xrr_pkg::req_e'(req_type_i))
      xrr_pkg::REQ_FRAC: begin
        cmd_o.op = xrr_pkg::OP_FRAC;
      end
      xrr_pkg::REQ_MAX: begin
        if (arg_a_i[63] || arg_a_i == 64'd0) begin
          cmd_o.op = xrr_pkg::OP_ZERO;
        end else begin
          cmd_o.op   = xrr_pkg::OP_MOD;
          cmd_o.diff = arg_a_i;
        end
      end
      xrr_pkg::REQ_RANGE: begin
        cmd_o.op   = xrr_pkg::OP_MOD;
        cmd_o.lo   = swap ? arg_b_i : arg_a_i;
        cmd_o.diff = swap ? (arg_a_i - arg_b_i) : (arg_b_i - arg_a_i);
      end
      xrr_pkg::REQ_SEED: begin
        cmd_o.op = xrr_pkg::OP_SEED;
        cmd_o.lo = arg_a_i;
      end
      default: begin
        cmd_o.op = xrr_pkg::OP_FRAC;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/xrr_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module xrr_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  xrr_pkg::cmd_t      wdata_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output xrr_pkg::cmd_t      rdata_o,
  output logic               empty_o
);

  xrr_pkg::cmd_t                 mem_q [xrr_pkg::FIFO_DEPTH];
  logic [xrr_pkg::PTR_W-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [xrr_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign full_o  = (cnt_q == xrr_pkg::CNT_W'(xrr_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == xrr_pkg::PTR_W'(xrr_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == xrr_pkg::PTR_W'(xrr_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

### src/xrr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module xrr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  xrr_pkg::cmd_t      cmd_i,
  input  wire logic          cmd_empty_i,
  output logic               cmd_rd_o,
  output logic               empty,
  input  wire logic          pop,
  output logic [63:0]        int_value_o,
  output logic [52:0]        fraction_o
);

  xrr_pkg::state_e state_q, state_d;

  logic [63:0] w_q [4];
  logic [63:0] w_d [4];
  xrr_pkg::op_e op_q, op_d;
  logic [63:0] lo_q, lo_d, span_q, span_d;
  logic [63:0] t_q, t_d, rem_q, rem_d, dvd_q, dvd_d;
  logic [xrr_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [63:0] seed_q, seed_d, z_q, z_d, acc_q, acc_d;
  logic [1:0]  mc_q, mc_d, rnd_q, rnd_d;
  logic        mph_q, mph_d;
  logic [63:0] wint_q, wint_d;
  logic [52:0] wfrac_q, wfrac_d;
  logic        res_valid_q, res_valid_d;
  logic [63:0] res_int_q, res_int_d;
  logic [52:0] res_frac_q, res_frac_d;

  logic [63:0] w2x, w3x, rot7, raw_new, mconst, seed_sum;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [64:0] r65;
  logic        out_free;

  // Generator step terms.
  assign w2x      = w_q[2] ^ w_q[0];
  assign w3x      = w_q[3] ^ w_q[1];
  assign rot7     = {t_q[56:0], t_q[63:57]};
  assign raw_new  = rot7 + {rot7[60:0], 3'b000};
  assign seed_sum = seed_q + xrr_pkg::SM_GOLDEN;

  // One shared 32x32 multiplier for the seeding rounds.
  assign mconst = mph_q ? xrr_pkg::SM_MUL2 : xrr_pkg::SM_MUL1;
  assign mul_a  = (mc_q == 2'd1) ? z_q[63:32] : z_q[31:0];
  assign mul_b  = (mc_q == 2'd2) ? mconst[63:32] : mconst[31:0];
  assign prod   = 64'(mul_a) * 64'(mul_b);

  // Divider step: shift in one dividend bit.
  assign r65 = {rem_q, dvd_q[63]};

  assign out_free = !res_valid_q || pop;
  assign cmd_rd_o = (state_q == xrr_pkg::ST_IDLE) && !cmd_empty_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xrr_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          unique case (cmd_i.op)
            xrr_pkg::OP_ZERO: state_d = xrr_pkg::ST_HOLD;
            xrr_pkg::OP_SEED: state_d = xrr_pkg::ST_SD_ADD;
            default:          state_d = xrr_pkg::ST_MUL5;
          endcase
        end
      end
      xrr_pkg::ST_MUL5: state_d = xrr_pkg::ST_MUL9;
      xrr_pkg::ST_MUL9: begin
        if (op_q == xrr_pkg::OP_FRAC) begin
          state_d = xrr_pkg::ST_HOLD;
        end else if (span_q == 64'd0) begin
          state_d = xrr_pkg::ST_SUM;
        end else begin
          state_d = xrr_pkg::ST_DIV;
        end
      end
      xrr_pkg::ST_DIV: begin
        if (dcnt_q == xrr_pkg::DCNT_W'(xrr_pkg::DIV_STEPS - 1)) begin
          state_d = xrr_pkg::ST_SUM;
        end
      end
      xrr_pkg::ST_SUM: state_d = xrr_pkg::ST_HOLD;
      xrr_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = xrr_pkg::ST_IDLE;
        end
      end
      xrr_pkg::ST_SD_ADD: state_d = xrr_pkg::ST_SD_X30;
      xrr_pkg::ST_SD_X30: state_d = xrr_pkg::ST_SD_MUL;
      xrr_pkg::ST_SD_MUL: begin
        if (mc_q == 2'd2) begin
          state_d = mph_q ? xrr_pkg::ST_SD_X31 : xrr_pkg::ST_SD_X27;
        end
      end
      xrr_pkg::ST_SD_X27: state_d = xrr_pkg::ST_SD_MUL;
      xrr_pkg::ST_SD_X31: begin
        state_d = (rnd_q == 2'd3) ? xrr_pkg::ST_IDLE : xrr_pkg::ST_SD_ADD;
      end
      default: state_d = xrr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and register updates per state.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w_d[i] = w_q[i];
    end
    op_d        = op_q;
    lo_d        = lo_q;
    span_d      = span_q;
    t_d         = t_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    dcnt_d      = dcnt_q;
    seed_d      = seed_q;
    z_d         = z_q;
    acc_d       = acc_q;
    mc_d        = mc_q;
    rnd_d       = rnd_q;
    mph_d       = mph_q;
    wint_d      = wint_q;
    wfrac_d     = wfrac_q;
    res_valid_d = res_valid_q && !pop;
    res_int_d   = res_int_q;
    res_frac_d  = res_frac_q;
    unique case (state_q)
      xrr_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          op_d    = cmd_i.op;
          lo_d    = cmd_i.lo;
          span_d  = cmd_i.diff + 64'd1;
          seed_d  = cmd_i.lo;
          rnd_d   = 2'd0;
          wint_d  = '0;
          wfrac_d = '0;
        end
      end
      xrr_pkg::ST_MUL5: begin
        t_d    = w_q[1] + {w_q[1][61:0], 2'b00};
        w_d[0] = w_q[0] ^ w3x;
        w_d[1] = w_q[1] ^ w2x;
        w_d[2] = w2x ^ {w_q[1][63-xrr_pkg::SHIFT_B:0], xrr_pkg::SHIFT_B'(0)};
        w_d[3] = {w3x[63-xrr_pkg::ROT_D:0], w3x[63:64-xrr_pkg::ROT_D]};
      end
      xrr_pkg::ST_MUL9: begin
        // Only a fraction draw carries the fraction field.
        wfrac_d = (op_q == xrr_pkg::OP_FRAC) ? raw_new[63:11] : '0;
        rem_d   = (span_q == 64'd0) ? raw_new : '0;
        dvd_d   = raw_new;
        dcnt_d  = '0;
      end
      xrr_pkg::ST_DIV: begin
        rem_d  = (r65 >= {1'b0, span_q}) ? 64'(r65 - {1'b0, span_q}) : r65[63:0];
        dvd_d  = {dvd_q[62:0], 1'b0};
        dcnt_d = dcnt_q + 1'b1;
      end
      xrr_pkg::ST_SUM: begin
        wint_d = lo_q + rem_q;
      end
      xrr_pkg::ST_HOLD: begin
        if (out_free) begin
          res_valid_d = 1'b1;
          res_int_d   = wint_q;
          res_frac_d  = wfrac_q;
        end
      end
      xrr_pkg::ST_SD_ADD: begin
        seed_d = seed_sum;
        z_d    = seed_sum;
      end
      xrr_pkg::ST_SD_X30: begin
        z_d   = z_q ^ (z_q >> 30);
        mph_d = 1'b0;
        mc_d  = 2'd0;
      end
      xrr_pkg::ST_SD_MUL: begin
        if (mc_q == 2'd0) begin
          acc_d = prod;
          mc_d  = 2'd1;
        end else if (mc_q == 2'd1) begin
          acc_d = acc_q + {prod[31:0], 32'd0};
          mc_d  = 2'd2;
        end else begin
          z_d  = acc_q + {prod[31:0], 32'd0};
          mc_d = 2'd0;
        end
      end
      xrr_pkg::ST_SD_X27: begin
        z_d   = z_q ^ (z_q >> 27);
        mph_d = 1'b1;
        mc_d  = 2'd0;
      end
      xrr_pkg::ST_SD_X31: begin
        w_d[rnd_q] = z_q ^ (z_q >> 31);
        rnd_d      = rnd_q + 1'b1;
      end
      default: begin
        res_valid_d = res_valid_q && !pop;
      end
    endcase
  end

  // Control state and generator words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xrr_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
      w_q[0]      <= xrr_pkg::W_INIT0;
      w_q[1]      <= xrr_pkg::W_INIT1;
      w_q[2]      <= xrr_pkg::W_INIT2;
      w_q[3]      <= xrr_pkg::W_INIT3;
      dcnt_q      <= '0;
      mc_q        <= '0;
      rnd_q       <= '0;
      mph_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= w_d[i];
      end
      dcnt_q      <= dcnt_d;
      mc_q        <= mc_d;
      rnd_q       <= rnd_d;
      mph_q       <= mph_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    lo_q       <= lo_d;
    span_q     <= span_d;
    t_q        <= t_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    seed_q     <= seed_d;
    z_q        <= z_d;
    acc_q      <= acc_d;
    wint_q     <= wint_d;
    wfrac_q    <= wfrac_d;
    res_int_q  <= res_int_d;
    res_frac_q <= res_frac_d;
  end

  assign empty       = !res_valid_q;
  assign int_value_o = res_int_q;
  assign fraction_o  = res_frac_q;

endmodule
`default_nettype wire

### src/xoshiro256ss_ranged_random_core.sv
// Ranged random-number core on a xoshiro256** generator.
// Input channel: req_type_i, arg_a_i, arg_b_i; a beat is taken when push is
// high and full is low. Requests land in a two-entry command queue, so the
// front keeps taking beats while the back end works.
// Result channel: int_value_o and fraction_o are valid while empty is low;
// pop with empty low takes the beat. Reseed requests give no result.
// The back end starts a request only when idle, so it works on one at a
// time. Steps after pickup: fraction draw: generator step, then output
// register; max not positive: straight to the output register; max or
// range draw: generator step, the 64-step shift-subtract remainder unit
// (skipped when the span covers all 64-bit values) and the bound sum;
// reseed: four rounds on one shared 32x32 multiplier.
// Reset loads the four fixed generator words and empties both queues.
// When the receiver stalls, the finished result sits in the output
// register; the back end finishes the next request and then waits, and
// the input queue fills until full goes high.
`timescale 1ns / 1ps
`default_nettype none
module xoshiro256ss_ranged_random_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [63:0] arg_a_i,
  input  wire logic [63:0] arg_b_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      int_value_o,
  output logic [52:0]      fraction_o
);

  xrr_pkg::cmd_t in_cmd, q_cmd;
  logic          q_empty, q_rd;

  // Request classification.
  xrr_front u_front (
    .req_type_i (req_type_i),
    .arg_a_i    (arg_a_i),
    .arg_b_i    (arg_b_i),
    .cmd_o      (in_cmd)
  );

  // Command queue between front and back.
  xrr_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (in_cmd),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_cmd),
    .empty_o (q_empty)
  );

  // Generator, remainder unit and output register.
  xrr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_empty_i (q_empty),
    .cmd_rd_o    (q_rd),
    .empty       (empty),
    .pop         (pop),
    .int_value_o (int_value_o),
    .fraction_o  (fraction_o)
  );

endmodule
`default_nettype wire

### src/xrr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module xrr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [63:0] int_value_o,
  input wire logic [52:0] fraction_o
);

  // Reset leaves both queues empty.
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not empty during reset");

  // A fraction result never carries an integer part.
  a_frac_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && fraction_o != 53'd0) |-> (int_value_o == 64'd0))
    else $error("fraction and integer both nonzero");

  // A waiting result is not dropped or changed.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(int_value_o) && $stable(fraction_o)))
    else $error("waiting result changed");

  // The input queue only fills up right after a pushed beat.
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a pushed beat");

endmodule

bind xoshiro256ss_ranged_random_core xrr_checker u_chk (.*);
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import xrr_pkg::*;

  typedef struct {
    logic [63:0] int_value;
    logic [52:0] fraction;
  } draw_t;

  typedef struct {
    req_e        kind;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;      // expected draw typed into the table
    logic [63:0] want_int;
    logic [52:0] want_frac;
  } row_t;

  localparam logic [63:0] MIN64 = 64'h8000000000000000;
  localparam logic [63:0] MAX64 = 64'h7fffffffffffffff;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [1:0] req_type;
  logic [63:0] arg_a, arg_b;
  logic [63:0] int_value;
  logic [52:0] fraction;

  logic [63:0] gen_w [4];
  draw_t pending_draws [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  xoshiro256ss_ranged_random_core u_dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .req_type_i(req_type), .arg_a_i(arg_a), .arg_b_i(arg_b),
    .empty(empty), .pop(pop), .int_value_o(int_value), .fraction_o(fraction)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rotl(logic [63:0] v, int k);
    return (v << k) | (v >> (64 - k));
  endfunction

  // Advance the generator words one step and return the scrambled output.
  function automatic logic [63:0] next_output();
    logic [63:0] w0, w1, w2, w3, o;
    w0 = gen_w[0];
    w1 = gen_w[1];
    w2 = gen_w[2] ^ w0;
    w3 = gen_w[3] ^ w1;
    o = rotl(w1 * 64'd5, 7) * 64'd9;
    gen_w[0] = w0 ^ w3;
    gen_w[1] = w1 ^ w2;
    gen_w[2] = w2 ^ (w1 << 17);
    gen_w[3] = rotl(w3, 45);
    return o;
  endfunction

  // Compute the draw for one request; returns 0 when it gives none.
  function automatic bit predict_draw(req_e kind, logic [63:0] a,
                                      logic [63:0] b, output draw_t d);
    logic [63:0] lo, hi, span, raw, s, z;
    d.int_value = '0;
    d.fraction = '0;
    case (kind)
      REQ_FRAC: begin
        d.fraction = 53'(next_output() >> 11);
      end
      REQ_MAX: begin
        if (!a[63] && a != 0) d.int_value = next_output() % (a + 64'd1);
      end
      REQ_RANGE: begin
        lo = a;
        hi = b;
        if ($signed(b) < $signed(a)) begin
          lo = b;
          hi = a;
        end
        span = hi - lo + 64'd1;
        raw = next_output();
        d.int_value = (span == 0) ? lo + raw : lo + raw % span;
      end
      default: begin
        s = a;
        for (int i = 0; i < 4; i++) begin
          s = s + SM_GOLDEN;
          z = (s ^ (s >> 30)) * SM_MUL1;
          z = (z ^ (z >> 27)) * SM_MUL2;
          gen_w[i] = z ^ (z >> 31);
        end
        return 0;
      end
    endcase
    return 1;
  endfunction

  // Directed rows. Known draws in the table do not depend on the generator words.
  row_t rows [$];
  initial begin
    // first output from reset words: rotl(w1*5,7)*9
    rows.push_back('{REQ_MAX, 64'd0, 64'd0, 1, 64'd0, 53'd0});
    rows.push_back('{REQ_MAX, MIN64, 64'd0, 1, 64'd0, 53'd0});
    rows.push_back('{REQ_MAX, 64'hffffffffffffffff, MAX64, 1, 64'd0, 53'd0});
    rows.push_back('{REQ_FRAC, MAX64, MIN64, 0, 0, 0});
    rows.push_back('{REQ_MAX, 64'd1, 64'd0, 0, 0, 0});
    rows.push_back('{REQ_MAX, MAX64, 64'hffffffffffffffff, 0, 0, 0});
    rows.push_back('{REQ_RANGE, 64'd5, 64'd5, 1, 64'd5, 53'd0});
    rows.push_back('{REQ_RANGE, 64'd100, 64'd10, 0, 0, 0});
    rows.push_back('{REQ_RANGE, MIN64, MAX64, 0, 0, 0});
    rows.push_back('{REQ_RANGE, MAX64, MIN64, 0, 0, 0});
    rows.push_back('{REQ_RANGE, -64'sd1, 64'd0, 0, 0, 0});
    rows.push_back('{REQ_RANGE, MIN64, -64'sd2, 0, 0, 0});
    rows.push_back('{REQ_RANGE, MAX64, MAX64, 1, MAX64, 53'd0});
    rows.push_back('{REQ_SEED, 64'd0, 64'd0, 0, 0, 0});
    rows.push_back('{REQ_FRAC, 64'd0, 64'd0, 0, 0, 0});
    rows.push_back('{REQ_SEED, 64'hffffffffffffffff, MAX64, 0, 0, 0});
    rows.push_back('{REQ_MAX, MAX64, 64'd0, 0, 0, 0});
    rows.push_back('{REQ_RANGE, MIN64, MIN64, 1, MIN64, 53'd0});
    rows.push_back('{REQ_FRAC, 64'd0, 64'd0, 0, 0, 0});
  end

  // Send one beat and record the expected draw at acceptance.
  task automatic send_beat(req_e kind, logic [63:0] a, logic [63:0] b,
                           bit known, logic [63:0] wi, logic [52:0] wf);
    draw_t d;
    push <= 1'b1;
    req_type <= kind;
    arg_a <= a;
    arg_b <= b;
    do @(posedge clk); while (full);
    if (predict_draw(kind, a, b, d)) begin
      if (known && (d.int_value !== wi || d.fraction !== wf)) begin
        $error("table row disagrees with predictor: int %h frac %h", wi, wf);
        errors++;
      end
      pending_draws.push_back(d);
    end
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0: v = MIN64;
      1: v = MAX64;
      2: v = $urandom_range(0, 20);
      3: v = -$signed(64'($urandom_range(0, 20)));
      4: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  // Sender: directed table, then random bursts with gaps.
  initial begin
    logic [63:0] a, b;
    req_e kind;
    int burst;
    push = 0;
    req_type = '0;
    arg_a = '0;
    arg_b = '0;
    gen_w[0] = W_INIT0;
    gen_w[1] = W_INIT1;
    gen_w[2] = W_INIT2;
    gen_w[3] = W_INIT3;
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (rows[i])
      send_beat(rows[i].kind, rows[i].a, rows[i].b, rows[i].known,
                rows[i].want_int, rows[i].want_frac);
    push <= 0;
    // hold off until every expected draw is back
    while (pending_draws.size() != 0) @(posedge clk);
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
        kind = req_e'($urandom_range(0, 3));
        a = rand64();
        b = rand64();
        send_beat(kind, a, b, 0, 0, 0);
      end
      push <= 0;
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 150)) @(posedge clk);
      else @(posedge clk);
    end
    push <= 0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Receiver: stalls in runs, with long stretches of steady popping.
  initial begin
    int run;
    bit stalling;
    pop = 0;
    stalling = 0;
    @(posedge rst_n);
    forever begin
      run = $urandom_range(1, stalling ? 90 : 200);
      repeat (run) begin
        pop <= !stalling;
        @(posedge clk);
      end
      stalling = ($urandom_range(0, 2) == 0);
    end
  end

  // Check each popped beat and watch for a stalled run.
  always @(posedge clk) begin
    draw_t d;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_draws.size() == 0) begin
          $error("unexpected result beat: int %h frac %h", int_value, fraction);
          errors++;
        end else begin
          d = pending_draws.pop_front();
          if (int_value !== d.int_value) begin
            $error("int_value: expected %h, actual %h", d.int_value, int_value);
            errors++;
          end
          if (fraction !== d.fraction) begin
            $error("fraction: expected %h, actual %h", d.fraction, fraction);
            errors++;
          end
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
